// ----- hdl/lrfd_pkg.sv -----
// shared types, constants and hex helpers for the lens remote frame decoder
`default_nettype none

package lrfd_pkg;

   // frame buffer limit, in characters
   localparam int MAX_FRAME = 32;
   localparam int COUNT_W   = $clog2(MAX_FRAME + 1);
   // cells in the row: the head of the frame is captured in cells 0..11,
   // the tail taps used are cells 3..6
   localparam int NUM_CELLS = 12;

   localparam logic [15:0] POS_RESET = 16'd3600;

   typedef logic [7:0] char_type;

   localparam char_type CH_AT    = 8'h40;
   localparam char_type CH_NL    = 8'h0A;
   localparam char_type CH_0     = 8'h30;
   localparam char_type CH_1     = 8'h31;
   localparam char_type CH_7     = 8'h37;
   localparam char_type CH_9     = 8'h39;
   localparam char_type CH_A_UP  = 8'h41;
   localparam char_type CH_F_UP  = 8'h46;
   localparam char_type CH_A_LO  = 8'h61;
   localparam char_type CH_F_LO  = 8'h66;

   // axis mask codes carried in the fourth frame character
   localparam logic [2:0] MASK_FOCUS      = 3'd1;
   localparam logic [2:0] MASK_ZOOM       = 3'd2;
   localparam logic [2:0] MASK_FOCUS_ZOOM = 3'd3;
   localparam logic [2:0] MASK_IRIS       = 3'd4;
   localparam logic [2:0] MASK_FOCUS_IRIS = 3'd5;
   localparam logic [2:0] MASK_ZOOM_IRIS  = 3'd6;
   localparam logic [2:0] MASK_ALL        = 3'd7;

   typedef enum logic [1:0] {
      EV_CALIBRATE = 2'd0,
      EV_POSITION  = 2'd1,
      EV_OVERFLOW  = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    focus;
      logic [15:0]    zoom;
      logic [15:0]    iris;
   } rsp_item_type;

   typedef struct packed {
      logic         hit;
      rsp_item_type item;
   } decode_result_type;

   typedef struct packed {
      char_type tail;
      char_type head;
   } cell_data_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input char_type c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CH_0 && c <= CH_9) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= CH_A_UP && c <= CH_F_UP) || (c >= CH_A_LO && c <= CH_F_LO)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // four characters, first is the most significant digit; bad digit gives 0
   function automatic logic [15:0] hex4(input char_type a, input char_type b,
                                        input char_type c, input char_type d);
      logic [4:0] da, db, dc, dd;
      logic [15:0] r;
      da = hex_digit(a);
      db = hex_digit(b);
      dc = hex_digit(c);
      dd = hex_digit(d);
      r  = 16'd0;
      if (da[4] && db[4] && dc[4] && dd[4]) begin
         r = {da[3:0], db[3:0], dc[3:0], dd[3:0]};
      end
      return r;
   endfunction

   // one-character group read twice
   function automatic logic [15:0] hex2(input char_type a);
      logic [4:0] da;
      logic [15:0] r;
      da = hex_digit(a);
      r  = 16'd0;
      if (da[4]) begin
         r = {8'h00, da[3:0], da[3:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lrfd_cell.sv -----
// one cell of the character row: a tail tap that shifts and a head slot that captures
`default_nettype none

module lrfd_cell
   import lrfd_pkg::*;
(
   input  logic          clock,
   input  logic          shift_en,
   input  char_type      shift_in,
   input  logic          capture,
   input  char_type      capture_data,
   output cell_data_type data_out
);

   char_type tail_ff, tail_in;
   char_type head_ff, head_in;

   always_comb begin
      tail_in = shift_en ? shift_in : tail_ff;
      head_in = capture ? capture_data : head_ff;
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      head_ff <= head_in;
   end

   assign data_out = '{tail: tail_ff, head: head_ff};

endmodule

`default_nettype wire

// ----- hdl/lrfd_decode.sv -----
// frame decode on newline: calibrate check, axis mask and hex groups
`default_nettype none

module lrfd_decode
   import lrfd_pkg::*;
(
   input  char_type          head [NUM_CELLS],
   input  char_type          tail [NUM_CELLS],
   input  logic [COUNT_W-1:0] frame_count,
   input  logic [15:0]       focus_cur,
   input  logic [15:0]       zoom_cur,
   input  logic [15:0]       iris_cur,
   output decode_result_type result
);

   logic [COUNT_W-1:0] len;
   logic [COUNT_W-1:0] pl;
   logic               calib;
   logic               cmd;
   logic [2:0]         mask;
   logic [15:0]        head_val, mid_val, tail_val, single_val;
   logic [15:0]        focus_new, zoom_new, iris_new;

   always_comb begin
      // last character before the newline is dropped
      len  = frame_count - COUNT_W'(1);
      pl   = (len >= COUNT_W'(6)) ? len - COUNT_W'(6) : len - COUNT_W'(4);
      mask = head[3][2:0];

      calib = (len == COUNT_W'(6)) && head[0] == CH_AT && head[1] == CH_0 &&
              head[2] == CH_F_UP && head[3] == CH_F_UP && head[4] == CH_7 &&
              head[5] == CH_0;
      cmd   = (len >= COUNT_W'(4)) && head[1] == CH_1 && head[2] == CH_0 &&
              head[3] >= CH_1 && head[3] <= CH_7;

      // first payload group, up to four characters
      if (pl == COUNT_W'(0))      head_val = 16'd0;
      else if (pl == COUNT_W'(1)) head_val = hex2(head[4]);
      else if (pl == COUNT_W'(2)) head_val = hex4(head[4], head[5], head[4], head[5]);
      else if (pl == COUNT_W'(3)) head_val = hex4(head[5], head[6], head[4], head[5]);
      else                        head_val = hex4(head[6], head[7], head[4], head[5]);

      // middle group of a three-axis frame
      if (pl <= COUNT_W'(4))      mid_val = 16'd0;
      else if (pl == COUNT_W'(5)) mid_val = hex2(head[8]);
      else if (pl == COUNT_W'(6)) mid_val = hex4(head[8], head[9], head[8], head[9]);
      else if (pl == COUNT_W'(7)) mid_val = hex4(head[9], head[10], head[8], head[9]);
      else                        mid_val = hex4(head[10], head[11], head[8], head[9]);

      // last four payload characters sit in tail cells 6..3
      tail_val = (pl > COUNT_W'(4)) ? hex4(tail[4], tail[3], tail[6], tail[5]) : head_val;

      // single axis: whole payload as one group
      if (pl == COUNT_W'(0))      single_val = 16'd0;
      else if (pl == COUNT_W'(1)) single_val = hex2(head[4]);
      else                        single_val = hex4(tail[4], tail[3], head[4], head[5]);

      focus_new = focus_cur;
      zoom_new  = zoom_cur;
      iris_new  = iris_cur;
      unique case (mask)
         MASK_FOCUS:      focus_new = single_val;
         MASK_ZOOM:       zoom_new  = single_val;
         MASK_IRIS:       iris_new  = single_val;
         MASK_FOCUS_ZOOM: begin
            focus_new = head_val;
            zoom_new  = tail_val;
         end
         MASK_FOCUS_IRIS: begin
            focus_new = head_val;
            iris_new  = tail_val;
         end
         MASK_ZOOM_IRIS: begin
            zoom_new = head_val;
            iris_new = tail_val;
         end
         MASK_ALL: begin
            focus_new = head_val;
            zoom_new  = mid_val;
            iris_new  = tail_val;
         end
         default: ;
      endcase

      result.hit = 1'b0;
      result.item = '{kind: EV_CALIBRATE, focus: focus_cur, zoom: zoom_cur, iris: iris_cur};
      if (calib) begin
         result.hit = 1'b1;
      end else if (cmd) begin
         result.hit  = 1'b1;
         result.item = '{kind: EV_POSITION, focus: focus_new, zoom: zoom_new,
                         iris: iris_new};
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lens_remote_frame_decoder_top.sv -----
// top level of the lens remote frame decoder
// usage
//   req channel: one received ascii character per item in req_tdata
//   rsp channel: one event item, kind in rsp_tuser, positions in rsp_tdata
//   '@' opens (or reopens) a frame, newline closes it and triggers the decode;
//   characters outside a frame are ignored
//   each frame character is shifted into a row of cells; the first twelve frame
//   characters are also captured by position, so the decode reads fixed taps
//   throughput: one item per cycle while the skid stage is empty; the decode
//   after the cell row is combinational
//   the result of a newline (or of the overflowing character) is registered
//   as it is accepted, in the output register or, while rsp stalls, the skid stage
//   a frame longer than the buffer is dropped and an overflow event is issued
//   reset: frame state cleared, focus, zoom and iris back to 3600, no items held
//   rsp stall: an output register plus a one-item skid stage keep req_tready
//   high while one result waits; req_tready drops only when both are full
`default_nettype none

module lens_remote_frame_decoder_top
   import lrfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [15:0] focus_out, [31:16] zoom_out, [47:32] iris_out
   output logic [1:0]  rsp_tuser     // [1:0] event_kind
);

   // frame state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               in_frame_ff, in_frame_in;
   logic [15:0]        focus_ff, focus_in;
   logic [15:0]        zoom_ff, zoom_in;
   logic [15:0]        iris_ff, iris_in;

   // output register and skid stage
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_item_type       skid_item_ff, skid_item_in;

   logic               accept;
   logic               is_at, is_nl;
   logic               write_en, overflow, closing;
   logic [COUNT_W-1:0] wr_idx;
   logic               res_valid;
   rsp_item_type       res_item;
   logic               out_free;

   cell_data_type      cell_data [NUM_CELLS];
   char_type           head_taps [NUM_CELLS];
   char_type           tail_taps [NUM_CELLS];
   decode_result_type  dec;

   char_type           rx_char;

   assign rx_char    = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_at      = (rx_char == CH_AT);
   assign is_nl      = (rx_char == CH_NL);

   // an '@' always writes slot 0, other characters in an open frame but the newline append while room is left
   assign write_en = accept && (is_at ||
                     (in_frame_ff && !is_nl && count_ff < COUNT_W'(MAX_FRAME)));
   assign overflow = accept && !is_at && in_frame_ff && !is_nl &&
                     count_ff >= COUNT_W'(MAX_FRAME);
   assign closing  = accept && !is_at && in_frame_ff && is_nl;
   assign wr_idx   = is_at ? COUNT_W'(0) : count_ff;

   // row of cells: cell 0 takes the newest character, each passes it on
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      char_type shift_src;
      if (k == 0) begin : g_first
         assign shift_src = rx_char;
      end else begin : g_next
         assign shift_src = cell_data[k-1].tail;
      end

      lrfd_cell u_cell (
         .clock        (clock),
         .shift_en     (write_en),
         .shift_in     (shift_src),
         .capture      (write_en && wr_idx == COUNT_W'(k)),
         .capture_data (rx_char),
         .data_out     (cell_data[k])
      );

      assign head_taps[k] = cell_data[k].head;
      assign tail_taps[k] = cell_data[k].tail;
   end

   lrfd_decode u_decode (
      .head        (head_taps),
      .tail        (tail_taps),
      .frame_count (count_ff),
      .focus_cur   (focus_ff),
      .zoom_cur    (zoom_ff),
      .iris_cur    (iris_ff),
      .result      (dec)
   );

   // result of this item, if any
   always_comb begin
      res_valid = overflow || (closing && dec.hit);
      res_item  = dec.item;
      if (overflow) begin
         res_item = '{kind: EV_OVERFLOW, focus: focus_ff, zoom: zoom_ff, iris: iris_ff};
      end
   end

   // frame and position state
   always_comb begin
      count_in    = count_ff;
      in_frame_in = in_frame_ff;
      focus_in    = focus_ff;
      zoom_in     = zoom_ff;
      iris_in     = iris_ff;
      if (accept && is_at) begin
         count_in    = COUNT_W'(1);
         in_frame_in = 1'b1;
      end else if (overflow || closing) begin
         count_in    = COUNT_W'(0);
         in_frame_in = 1'b0;
      end else if (write_en) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (closing && dec.hit) begin
         focus_in = dec.item.focus;
         zoom_in  = dec.item.zoom;
         iris_in  = dec.item.iris;
      end
   end

   // output register with skid stage behind it
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // no item is taken while the skid stage is full
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_item_in  = res_item;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         in_frame_ff   <= 1'b0;
         focus_ff      <= POS_RESET;
         zoom_ff       <= POS_RESET;
         iris_ff       <= POS_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         in_frame_ff   <= in_frame_in;
         focus_ff      <= focus_in;
         zoom_ff       <= zoom_in;
         iris_ff       <= iris_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.kind;
   assign rsp_tdata  = {out_item_ff.iris, out_item_ff.zoom, out_item_ff.focus};

endmodule

`default_nettype wire

// ----- tb/tb_lens_remote_frame_decoder_top.sv -----
// self-checking testbench for the lens remote frame decoder: directed frames, then random traffic
module tb_lens_remote_frame_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lrfd_pkg::*;

   // generous cycle budget, far above the slowest legal run
   localparam int RUN_LIMIT    = 400000;
   // characters that reach the frame logic in the random part
   localparam int RANDOM_CHARS = 200;
   // chance in a hundred that a side idles in a given cycle
   localparam int IDLE_PCT     = 23;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [15:0] focus_out, [31:16] zoom_out, [47:32] iris_out
   logic [1:0]  rsp_tuser;            // [1:0] event_kind

   lens_remote_frame_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // decoder state as the testbench sees it
   // ---------------------------------------------------------------------
   char_type     line_buf [MAX_FRAME];   // characters of the open frame, '@' first
   int unsigned  line_len;               // characters held, '@' included
   bit           in_line;                // a frame is open
   logic [15:0]  focus_now;
   logic [15:0]  zoom_now;
   logic [15:0]  iris_now;

   rsp_item_type expected_events [$];    // events still owed by the block, oldest first
   int unsigned  mismatches  = 0;
   int unsigned  frame_chars = 0;        // items that reached the frame logic
   int unsigned  cycles      = 0;
   bit           no_idle     = 1'b0;     // set during the burst stretch, both sides run flat out

   // nibble value of a hex character, -1 when it is not one
   function automatic int hex_nibble(input char_type c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
      if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
      return -1;
   endfunction

   function automatic char_type buf_char(input int unsigned idx);
      return (idx < MAX_FRAME) ? line_buf[idx] : 8'h00;
   endfunction

   // a group is read as its last two characters, then its first two (fewer if short)
   function automatic logic [15:0] group_value(input int unsigned start_idx,
                                               input int unsigned width_chars);
      char_type    digits [4];
      int unsigned half;
      int unsigned n;
      int unsigned k;
      int          nib;
      logic [15:0] acc;
      half = (width_chars < 2) ? width_chars : 2;
      n    = 0;
      acc  = 16'd0;
      for (k = 0; k < half; k++) begin
         digits[n] = buf_char(start_idx + width_chars - half + k);
         n++;
      end
      for (k = 0; k < half; k++) begin
         digits[n] = buf_char(start_idx + k);
         n++;
      end
      // an empty group reads as zero
      if (n == 0) return 16'd0;
      for (k = 0; k < n; k++) begin
         nib = hex_nibble(digits[k]);
         // any bad digit zeroes the whole group
         if (nib < 0) return 16'd0;
         acc = {acc[11:0], nib[3:0]};
      end
      return acc;
   endfunction

   // decode of a closed frame; the character just before the newline is not part of it
   function automatic bit decode_line(output rsp_item_type ev);
      int unsigned body;
      int unsigned pay;
      int unsigned grp;
      int unsigned mid;
      logic [2:0]  axes;
      logic [15:0] v1;
      logic [15:0] v2;
      logic [15:0] v3;
      ev   = '{kind: EV_CALIBRATE, focus: focus_now, zoom: zoom_now, iris: iris_now};
      body = line_len - 1;
      if (body == 6 && {line_buf[0], line_buf[1], line_buf[2], line_buf[3], line_buf[4],
                        line_buf[5]} == "@0FF70") begin
         return 1'b1;
      end
      // short frames and other commands are silently dropped
      if (body < 4 || line_buf[1] != CH_1 || line_buf[2] != CH_0) return 1'b0;
      if (line_buf[3] < CH_1 || line_buf[3] > CH_7) return 1'b0;
      axes = 3'(line_buf[3] - CH_0);
      // two trailing characters are not payload once the frame is long enough
      pay  = (body >= 6) ? body - 6 : body - 4;
      grp  = (pay < 4) ? pay : 4;
      case (axes)
         MASK_FOCUS: focus_now = group_value(4, pay);
         MASK_ZOOM:  zoom_now  = group_value(4, pay);
         MASK_IRIS:  iris_now  = group_value(4, pay);
         MASK_ALL: begin
            mid = (pay > 4) ? ((pay - 4 < 4) ? pay - 4 : 4) : 0;
            v1  = group_value(4, grp);
            v2  = group_value(8, mid);
            v3  = group_value(4 + pay - grp, grp);
            focus_now = v1;
            zoom_now  = v2;
            iris_now  = v3;
         end
         default: begin
            // two axes: first four payload characters, then the last four
            v1 = group_value(4, grp);
            v2 = group_value(4 + pay - grp, grp);
            if (axes == MASK_FOCUS_ZOOM) begin
               focus_now = v1;
               zoom_now  = v2;
            end else if (axes == MASK_FOCUS_IRIS) begin
               focus_now = v1;
               iris_now  = v2;
            end else begin
               zoom_now = v1;
               iris_now = v2;
            end
         end
      endcase
      ev = '{kind: EV_POSITION, focus: focus_now, zoom: zoom_now, iris: iris_now};
      return 1'b1;
   endfunction

   // advance the expected state by one accepted character; returns 1 when an event is due
   function automatic bit predict_char(input char_type c, output rsp_item_type ev);
      bit hit;
      ev = '{kind: EV_CALIBRATE, focus: focus_now, zoom: zoom_now, iris: iris_now};
      if (c == CH_AT || in_line) frame_chars++;
      // '@' always (re)opens a frame
      if (c == CH_AT) begin
         line_buf[0] = c;
         line_len    = 1;
         in_line     = 1'b1;
         return 1'b0;
      end
      if (!in_line) return 1'b0;
      if (c == CH_NL) begin
         in_line  = 1'b0;
         hit      = decode_line(ev);
         line_len = 0;
         return hit;
      end
      // no room left: drop the frame and flag it
      if (line_len >= MAX_FRAME) begin
         in_line  = 1'b0;
         line_len = 0;
         ev = '{kind: EV_OVERFLOW, focus: focus_now, zoom: zoom_now, iris: iris_now};
         return 1'b1;
      end
      line_buf[line_len] = c;
      line_len++;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // one item on the req side, with random idle cycles ahead of it
   task automatic send_char(input char_type c);
      rsp_item_type ev;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      if (predict_char(c, ev)) expected_events.push_back(ev);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic char_type hex_char();
      string digits = "0123456789ABCDEFabcdef";
      return digits[$urandom_range(21)];
   endfunction

   // any character that neither opens nor closes a frame
   function automatic char_type body_char();
      char_type c;
      do c = char_type'($urandom_range(255)); while (c == CH_AT || c == CH_NL);
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------
   // characters with no open frame, newline among them, are ignored
   task automatic test_outside_frames();
      send_char(8'h00);
      send_char(8'hFF);
      send_text("1011234\n");
   endtask

   task automatic test_calibrate();
      send_text("@0FF70Z\n");
      // one character short, and one too long: neither is a calibrate
      send_text("@0FF70\n");
      send_text("@0FF7012\n");
   endtask

   task automatic test_single_axis();
      send_text("@1011234CCx\n");    // focus, low byte first
      send_text("@102abcdXYq\n");    // zoom, lower-case digits
      send_text("@101ffff00q\n");    // top of range
      send_text("@1040000..q\n");    // bottom of range
      send_text("@1045q\n");         // one-character group read twice
      send_text("@104q\n");          // empty group reads as zero
   endtask

   task automatic test_multi_axis();
      send_text("@103123456789Cq\n");
      send_text("@105FEDCBA98zzq\n");
      send_text("@10600112233!!q\n");
      send_text("@107aaaabbbbcccc..q\n");
      send_text("@107123456q\n");    // three axes squeezed into a short payload
   endtask

   task automatic test_frame_faults();
      send_text("@1011G34CCx\n");    // bad hex digit
      send_text("@10@1021111CCx\n"); // '@' inside a frame starts it over
      send_text("@1081234CCx\n");    // axis mask out of range
      send_text("@2011234CCx\n");    // not a position command
      send_text("@1\n");             // too short to decode
      send_text("@\n");
   endtask

   task automatic test_overflow();
      // a frame that just fits is still decoded
      send_text("@107");
      for (int i = 0; i < 28; i++) send_char(hex_char());
      send_char(CH_NL);
      // one character more than the buffer holds
      send_char(CH_AT);
      for (int i = 0; i < 32; i++) send_char(hex_char());
      // the rest of the dropped frame is ignored
      send_text("12\n");
   endtask

   // ---------------------------------------------------------------------
   // random traffic: mostly well-formed position frames, some noise and broken frames
   // ---------------------------------------------------------------------
   task automatic test_random_traffic();
      int unsigned base;
      int unsigned pick;
      int unsigned n;
      base = frame_chars;
      while (frame_chars < base + RANDOM_CHARS) begin
         // a long stretch in the middle runs with no idling on either side
         no_idle = (frame_chars >= base + 60 && frame_chars < base + 140);
         pick    = $urandom_range(99);
         if (pick < 60) begin
            send_text("@10");
            send_char(($urandom_range(9) == 0) ? body_char()
                                               : char_type'(CH_0 + $urandom_range(1, 7)));
            n = ($urandom_range(3) == 0) ? $urandom_range(0, 14) : 4 * $urandom_range(1, 3) + 2;
            for (int k = 0; k < n; k++) begin
               send_char(($urandom_range(19) == 0) ? body_char() : hex_char());
            end
            send_char(body_char());
            send_char(CH_NL);
         end else if (pick < 68) begin
            send_text("@0FF70");
            if ($urandom_range(3) == 0) send_char(hex_char());
            send_char(body_char());
            send_char(CH_NL);
         end else if (pick < 75) begin
            // around the buffer limit, overflowing or not
            send_char(CH_AT);
            n = $urandom_range(29, 34);
            for (int k = 0; k < n; k++) send_char(body_char());
            send_char(CH_NL);
         end else if (pick < 85) begin
            if ($urandom_range(1) == 1) send_text("@10");
            else send_char(CH_AT);
            n = $urandom_range(0, 6);
            for (int k = 0; k < n; k++) begin
               send_char(($urandom_range(1) == 1) ? hex_char() : body_char());
            end
            send_char(CH_NL);
         end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) send_char(char_type'($urandom_range(255)));
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // result checking and rsp back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected item: event_kind %0d", rsp_tuser);
            mismatches++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("event_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[15:0] !== want.focus) begin
               $error("focus_out: expected %0d, got %0d", want.focus, rsp_tdata[15:0]);
               mismatches++;
            end
            if (rsp_tdata[31:16] !== want.zoom) begin
               $error("zoom_out: expected %0d, got %0d", want.zoom, rsp_tdata[31:16]);
               mismatches++;
            end
            if (rsp_tdata[47:32] !== want.iris) begin
               $error("iris_out: expected %0d, got %0d", want.iris, rsp_tdata[47:32]);
               mismatches++;
            end
         end
      end
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      // state after reset
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      line_len  = 0;
      in_line   = 1'b0;
      focus_now = POS_RESET;
      zoom_now  = POS_RESET;
      iris_now  = POS_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_outside_frames();
      test_calibrate();
      test_single_axis();
      test_multi_axis();
      test_frame_faults();
      test_overflow();
      test_random_traffic();

      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      // room for any stray late item to show up
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
